/* rtl/tgpf_pkg.sv */
// Package for the text glyph page framebuffer.
// Holds the operation codes, controller states, command/status structs and
// the 3x5 font table; used by every module of the block.
package tgpf_pkg;

  // Default panel size in pixels.
  localparam int PIXEL_WIDTH_DEF  = 128;
  localparam int PIXEL_HEIGHT_DEF = 64;

  // Fixed geometry of the character cell and the page layout.
  localparam int CELL_PITCH = 4;
  localparam int PAGE_ROWS  = 8;
  localparam int GLYPH_ROWS = 5;
  localparam int GLYPH_COLS = 3;

  // Width of a linear byte index while drawing: page (3 bits) times the widest
  // panel plus the pixel column stays below 4096.
  localparam int IDX_W = 12;
  // Width used for range compares against sizes up to 4096.
  localparam int CMP_W = 13;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_DRAW   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DRAW0,
    ST_DRAW1,
    ST_DRAW2,
    ST_DRAW3,
    ST_READ,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input fields, rewind the counter
    logic clr_wr;   // write zero at the sweep counter
    logic draw_rd;  // read the column byte selected by the counter
    logic draw_wr;  // write back the column byte read in the previous cycle
    logic cnt_inc;  // advance the counter
    logic result;   // present the read byte
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // counter is on the last framebuffer byte
  } stat_t;

  // One glyph: row r in [r], bit 2 is the leftmost column.
  typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_t;

  function automatic glyph_t mk_glyph(logic [2:0] r0, logic [2:0] r1, logic [2:0] r2,
                                      logic [2:0] r3, logic [2:0] r4);
    glyph_t g;
    g = {r4, r3, r2, r1, r0};
    return g;
  endfunction

  // Font lookup. Lowercase folds to uppercase; codes without a glyph show '?'.
  function automatic glyph_t glyph_lookup(logic [7:0] code);
    logic [7:0] c;
    glyph_t     g;
    c = code;
    if (code >= 8'h61 && code <= 8'h7A) begin
      c = code - 8'd32;
    end
    unique case (c)
      8'h20: g = mk_glyph(3'h0, 3'h0, 3'h0, 3'h0, 3'h0); // space
      8'h2D: g = mk_glyph(3'h0, 3'h0, 3'h7, 3'h0, 3'h0); // -
      8'h2E: g = mk_glyph(3'h0, 3'h0, 3'h0, 3'h0, 3'h2); // .
      8'h3A: g = mk_glyph(3'h0, 3'h2, 3'h0, 3'h2, 3'h0); // :
      8'h2F: g = mk_glyph(3'h1, 3'h1, 3'h2, 3'h4, 3'h4); // /
      8'h5F: g = mk_glyph(3'h0, 3'h0, 3'h0, 3'h0, 3'h7); // _
      8'h30: g = mk_glyph(3'h7, 3'h5, 3'h5, 3'h5, 3'h7);
      8'h31: g = mk_glyph(3'h2, 3'h6, 3'h2, 3'h2, 3'h7);
      8'h32: g = mk_glyph(3'h7, 3'h1, 3'h7, 3'h4, 3'h7);
      8'h33: g = mk_glyph(3'h7, 3'h1, 3'h3, 3'h1, 3'h7);
      8'h34: g = mk_glyph(3'h5, 3'h5, 3'h7, 3'h1, 3'h1);
      8'h35: g = mk_glyph(3'h7, 3'h4, 3'h7, 3'h1, 3'h7);
      8'h36: g = mk_glyph(3'h7, 3'h4, 3'h7, 3'h5, 3'h7);
      8'h37: g = mk_glyph(3'h7, 3'h1, 3'h1, 3'h1, 3'h1);
      8'h38: g = mk_glyph(3'h7, 3'h5, 3'h7, 3'h5, 3'h7);
      8'h39: g = mk_glyph(3'h7, 3'h5, 3'h7, 3'h1, 3'h7);
      8'h41: g = mk_glyph(3'h2, 3'h5, 3'h7, 3'h5, 3'h5);
      8'h42: g = mk_glyph(3'h6, 3'h5, 3'h6, 3'h5, 3'h6);
      8'h43: g = mk_glyph(3'h3, 3'h4, 3'h4, 3'h4, 3'h3);
      8'h44: g = mk_glyph(3'h6, 3'h5, 3'h5, 3'h5, 3'h6);
      8'h45: g = mk_glyph(3'h7, 3'h4, 3'h6, 3'h4, 3'h7);
      8'h46: g = mk_glyph(3'h7, 3'h4, 3'h6, 3'h4, 3'h4);
      8'h47: g = mk_glyph(3'h3, 3'h4, 3'h5, 3'h5, 3'h3);
      8'h48: g = mk_glyph(3'h5, 3'h5, 3'h7, 3'h5, 3'h5);
      8'h49: g = mk_glyph(3'h7, 3'h2, 3'h2, 3'h2, 3'h7);
      8'h4A: g = mk_glyph(3'h1, 3'h1, 3'h1, 3'h5, 3'h2);
      8'h4B: g = mk_glyph(3'h5, 3'h5, 3'h6, 3'h5, 3'h5);
      8'h4C: g = mk_glyph(3'h4, 3'h4, 3'h4, 3'h4, 3'h7);
      8'h4D: g = mk_glyph(3'h5, 3'h7, 3'h7, 3'h5, 3'h5);
      8'h4E: g = mk_glyph(3'h5, 3'h7, 3'h7, 3'h7, 3'h5);
      8'h4F: g = mk_glyph(3'h2, 3'h5, 3'h5, 3'h5, 3'h2);
      8'h50: g = mk_glyph(3'h6, 3'h5, 3'h6, 3'h4, 3'h4);
      8'h51: g = mk_glyph(3'h2, 3'h5, 3'h5, 3'h2, 3'h1);
      8'h52: g = mk_glyph(3'h6, 3'h5, 3'h6, 3'h5, 3'h5);
      8'h53: g = mk_glyph(3'h3, 3'h4, 3'h2, 3'h1, 3'h6);
      8'h54: g = mk_glyph(3'h7, 3'h2, 3'h2, 3'h2, 3'h2);
      8'h55: g = mk_glyph(3'h5, 3'h5, 3'h5, 3'h5, 3'h7);
      8'h56: g = mk_glyph(3'h5, 3'h5, 3'h5, 3'h5, 3'h2);
      8'h57: g = mk_glyph(3'h5, 3'h5, 3'h7, 3'h7, 3'h5);
      8'h58: g = mk_glyph(3'h5, 3'h5, 3'h2, 3'h5, 3'h5);
      8'h59: g = mk_glyph(3'h5, 3'h5, 3'h2, 3'h2, 3'h2);
      8'h5A: g = mk_glyph(3'h7, 3'h1, 3'h2, 3'h4, 3'h7);
      default: g = mk_glyph(3'h6, 3'h1, 3'h2, 3'h0, 3'h2); // '?' and unknown codes
    endcase
    return g;
  endfunction

endpackage

/* rtl/tgpf_ctrl.sv */
// Controller state machine of the text glyph page framebuffer.
// Sequences clear sweeps, draw read-modify-write steps and byte reads;
// depends on tgpf_pkg.
module tgpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [1:0]     mode_i,
  input  tgpf_pkg::stat_t stat_i,
  output tgpf_pkg::cmd_t  cmd_o,
  output logic           busy
);
  import tgpf_pkg::*;

  state_e state_q, state_d;

  // Reset lands in the clear sweep so the store starts out zeroed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (mode_e'(mode_i))
            MODE_CLEAR:  state_d = ST_CLEAR;
            MODE_DRAW:   state_d = ST_DRAW0;
            MODE_READ:   state_d = ST_READ;
            MODE_UNUSED: state_d = ST_IDLE;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAW0: begin
        cmd_o.draw_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ST_DRAW1;
      end
      ST_DRAW1: begin
        cmd_o.draw_wr = 1'b1;
        cmd_o.draw_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ST_DRAW2;
      end
      ST_DRAW2: begin
        cmd_o.draw_wr = 1'b1;
        cmd_o.draw_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = ST_DRAW3;
      end
      ST_DRAW3: begin
        cmd_o.draw_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        cmd_o.result = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tgpf_datapath.sv */
// Datapath of the text glyph page framebuffer: input registers, the
// framebuffer memory, the sweep/column counter and the glyph merge.
// Depends on tgpf_pkg; driven by tgpf_ctrl.
module tgpf_datapath #(
  parameter int PIXEL_WIDTH  = tgpf_pkg::PIXEL_WIDTH_DEF,
  parameter int PIXEL_HEIGHT = tgpf_pkg::PIXEL_HEIGHT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tgpf_pkg::cmd_t  cmd_i,
  input  logic [2:0]      text_line_i,
  input  logic [4:0]      cell_column_i,
  input  logic [7:0]      char_code_i,
  input  logic [9:0]      byte_address_i,
  output tgpf_pkg::stat_t stat_o,
  output logic [7:0]      read_data_o
);
  import tgpf_pkg::*;

  localparam int StoreBytes = (PIXEL_WIDTH * PIXEL_HEIGHT) / 8;
  localparam int AddrW      = $clog2(StoreBytes);

  logic [7:0]      fb_mem_q [StoreBytes];
  logic [7:0]      rdata_q;

  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] base_q, base_d;
  glyph_t           glyph_q;
  logic [GLYPH_COLS-1:0] col_ok_q, col_ok_d;
  logic [GLYPH_ROWS-1:0] row_ok_q, row_ok_d;
  logic [9:0]       addr_q;
  logic             addr_ok_q, addr_ok_d;

  logic [1:0]       rd_col, wr_col;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [AddrW-1:0] raddr, waddr;
  logic [7:0]       wdata, merged;
  logic             we;
  logic [CMP_W-1:0] col_px, col_idx;

  // Range checks for a draw and a read, worked out once when the beat is taken.
  always_comb begin
    base_d = IDX_W'(text_line_i) * IDX_W'(PIXEL_WIDTH)
           + IDX_W'({cell_column_i, 2'b00});
    for (int c = 0; c < GLYPH_COLS; c++) begin
      col_px  = CMP_W'({cell_column_i, 2'b00}) + CMP_W'(c);
      col_idx = CMP_W'(base_d) + CMP_W'(c);
      col_ok_d[c] = (CMP_W'(cell_column_i) < CMP_W'(PIXEL_WIDTH / CELL_PITCH))
                 && (col_px < CMP_W'(PIXEL_WIDTH))
                 && (col_idx < CMP_W'(StoreBytes));
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      row_ok_d[r] = (CMP_W'({text_line_i, 3'b000}) + CMP_W'(r)) < CMP_W'(PIXEL_HEIGHT);
    end
    addr_ok_d = CMP_W'(byte_address_i) < CMP_W'(StoreBytes);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q    <= base_d;
      glyph_q   <= glyph_lookup(char_code_i);
      col_ok_q  <= col_ok_d;
      row_ok_q  <= row_ok_d;
      addr_q    <= byte_address_i;
      addr_ok_q <= addr_ok_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stat_o.sweep_last = (cnt_q == AddrW'(StoreBytes - 1));

  // The byte read for one column is written back in the next cycle, while the
  // next column is being read.
  assign rd_col = cnt_q[1:0];
  assign wr_col = cnt_q[1:0] - 2'd1;
  assign rd_idx = base_q + IDX_W'(rd_col);
  assign wr_idx = base_q + IDX_W'(wr_col);

  always_comb begin
    merged = rdata_q;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (row_ok_q[r]) begin
        merged[r] = glyph_q[r][(GLYPH_COLS - 1) - int'(wr_col)];
      end
    end
  end

  always_comb begin
    raddr = cmd_i.draw_rd ? rd_idx[AddrW-1:0] : AddrW'(addr_q);
    if (cmd_i.clr_wr) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else begin
      we    = cmd_i.draw_wr && col_ok_q[wr_col];
      waddr = wr_idx[AddrW-1:0];
      wdata = merged;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      fb_mem_q[waddr] <= wdata;
    end
    rdata_q <= fb_mem_q[raddr];
  end

  assign read_data_o = (cmd_i.result && addr_ok_q) ? rdata_q : 8'h00;

endmodule

/* rtl/text_glyph_page_framebuffer_core.sv */
// Top level of the text glyph page framebuffer.
// Joins the controller (tgpf_ctrl) and the datapath (tgpf_datapath);
// depends on tgpf_pkg.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+---------------------------------------
//   command  | start, busy (out)          | mode_i, text_line_i, cell_column_i,
//            |                            | char_code_i, byte_address_i
//   result   | result_valid_o (1 cycle)   | read_data_o
//
// A command beat is taken at a rising edge where start is high and busy is low.
// A draw keeps busy high through ST_DRAW0 to ST_DRAW3: three read-modify-write column
// updates overlap on the framebuffer memory's one read and one write port.
// A read keeps busy high through ST_READ and ST_RESULT; its result beat is strobed in ST_RESULT.
// A clear walks the whole store, PIXEL_WIDTH * PIXEL_HEIGHT / 8 bytes (1024 at
// the default size), one byte a cycle. Clear and draw give no result; an unused
// mode is taken and dropped in the same cycle.
// After reset the same clearing pass runs with busy high. The receiver cannot
// stall a result beat.
module text_glyph_page_framebuffer_core #(
  parameter int PIXEL_WIDTH  = tgpf_pkg::PIXEL_WIDTH_DEF,
  parameter int PIXEL_HEIGHT = tgpf_pkg::PIXEL_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode_i,
  input  logic [2:0] text_line_i,
  input  logic [4:0] cell_column_i,
  input  logic [7:0] char_code_i,
  input  logic [9:0] byte_address_i,
  output logic       result_valid_o,
  output logic [7:0] read_data_o
);
  import tgpf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tgpf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  tgpf_datapath #(
    .PIXEL_WIDTH  (PIXEL_WIDTH),
    .PIXEL_HEIGHT (PIXEL_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .text_line_i    (text_line_i),
    .cell_column_i  (cell_column_i),
    .char_code_i    (char_code_i),
    .byte_address_i (byte_address_i),
    .stat_o         (stat),
    .read_data_o    (read_data_o)
  );

  // The result beat lasts exactly the one cycle the controller spends in its
  // result state.
  assign result_valid_o = cmd.result;

endmodule
